FILE: src/sit_pkg.sv
`timescale 1ns / 1ps
package sit_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 4;
  localparam int T_FRAC = 16;
endpackage

FILE: src/sit_if.sv
`timescale 1ns / 1ps
interface sit_in_if #(parameter int CW = sit_pkg::COORD_BITS_DEF) (input logic clk);
  logic valid;
  logic ready;
  logic signed [CW-1:0] ray_start_x;
  logic signed [CW-1:0] ray_start_y;
  logic signed [CW-1:0] ray_end_x;
  logic signed [CW-1:0] ray_end_y;
  logic signed [CW-1:0] wall_start_x;
  logic signed [CW-1:0] wall_start_y;
  logic signed [CW-1:0] wall_end_x;
  logic signed [CW-1:0] wall_end_y;
  logic wall_present;
  modport source (output valid, ray_start_x, ray_start_y, ray_end_x, ray_end_y,
                  wall_start_x, wall_start_y, wall_end_x, wall_end_y, wall_present,
                  input ready);
  modport sink (input valid, ray_start_x, ray_start_y, ray_end_x, ray_end_y,
                wall_start_x, wall_start_y, wall_end_x, wall_end_y, wall_present,
                output ready);
endinterface

interface sit_out_if #(parameter int CW = sit_pkg::COORD_BITS_DEF) (input logic clk);
  logic valid;
  logic ready;
  logic hit;
  logic parallel;
  logic signed [CW-1:0] cross_x;
  logic signed [CW-1:0] cross_y;
  modport source (output valid, hit, parallel, cross_x, cross_y, input ready);
  modport sink (input valid, hit, parallel, cross_x, cross_y, output ready);
endinterface

FILE: src/segment_intersection_test.sv
`timescale 1ns / 1ps
// Throughput is one item per cycle; a stall holds every stage in place.
// The 17-bit quotient comes from a restoring divider, one stage per fraction bit.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
module segment_intersection_test #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS = sit_pkg::FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  sit_in_if.sink in_ch,
  sit_out_if.source out_ch
);
  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int TF = sit_pkg::T_FRAC;
  localparam int NS = 5 + TF;
  localparam int IW = DW + TF + 2;
  localparam int FB_UNUSED = FRAC_BITS;

  logic [NS-1:0] v_r;
  logic en;
  assign en = !v_r[NS-1] || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: differences.
  logic signed [DW-1:0] a_r, b_r, c_r, d_r, e_r, f_r;
  logic signed [CW-1:0] x1_r [NS], y1_r [NS], x2_r [NS], y2_r [NS];
  logic pres_r [NS];
  // Stage 2: products.
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  // Stage 3: sums.
  logic signed [SW-1:0] den_r, tn_r, un_r;
  // Stage 4: normalize and test.
  logic [SW-1:0] dm_r, tm_r;
  logic ok_r [NS], par_r [NS], full_r;
  logic [SW-1:0] rr [TF+1], dd [TF+1];
  logic [16:0] qq [TF+1];

  localparam int L = 4 + TF;

  logic signed [SW-1:0] dn, tn, un;
  always_comb begin
    dn = den_r[SW-1] ? -den_r : den_r;
    tn = den_r[SW-1] ? -tn_r : tn_r;
    un = den_r[SW-1] ? -un_r : un_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[NS-2:0], in_ch.valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= DW'(in_ch.ray_start_x) - DW'(in_ch.ray_end_x);
      b_r <= DW'(in_ch.ray_start_y) - DW'(in_ch.ray_end_y);
      c_r <= DW'(in_ch.wall_start_x) - DW'(in_ch.wall_end_x);
      d_r <= DW'(in_ch.wall_start_y) - DW'(in_ch.wall_end_y);
      e_r <= DW'(in_ch.ray_start_x) - DW'(in_ch.wall_start_x);
      f_r <= DW'(in_ch.ray_start_y) - DW'(in_ch.wall_start_y);
      x1_r[0] <= in_ch.ray_start_x;
      y1_r[0] <= in_ch.ray_start_y;
      x2_r[0] <= in_ch.ray_end_x;
      y2_r[0] <= in_ch.ray_end_y;
      pres_r[0] <= in_ch.wall_present;
      for (int i = 1; i < NS; i++) begin
        x1_r[i] <= x1_r[i-1];
        y1_r[i] <= y1_r[i-1];
        x2_r[i] <= x2_r[i-1];
        y2_r[i] <= y2_r[i-1];
        pres_r[i] <= pres_r[i-1];
      end
      for (int i = 4; i < L; i++) begin
        ok_r[i] <= ok_r[i-1];
        par_r[i] <= par_r[i-1];
      end
      p0_r <= a_r * d_r;
      p1_r <= b_r * c_r;
      p2_r <= e_r * d_r;
      p3_r <= f_r * c_r;
      p4_r <= b_r * e_r;
      p5_r <= a_r * f_r;
      den_r <= SW'(p0_r) - SW'(p1_r);
      tn_r <= SW'(p2_r) - SW'(p3_r);
      un_r <= SW'(p4_r) - SW'(p5_r);
      par_r[3] <= den_r == '0;
      ok_r[3] <= (den_r != '0) && !tn[SW-1] && !un[SW-1] && (tn <= dn) && (un <= dn)
                 && pres_r[2];
      dm_r <= dn;
      tm_r <= tn;
      full_r <= tn == dn;
    end
  end

  assign rr[0] = full_r ? '0 : tm_r;
  assign dd[0] = dm_r;
  assign qq[0] = full_r ? 17'd1 : 17'd0;

  for (genvar g = 0; g < TF; g++) begin : g_div
    sit_div_stage #(.W(SW)) u_st (
      .clk(clk), .en(en), .r_in(rr[g]), .d_in(dd[g]), .q_in(qq[g]),
      .r_out(rr[g+1]), .d_out(dd[g+1]), .q_out(qq[g+1]));
  end

  // Final stage: q*(end-start) >>> 16 added to start and saturated on a hit; the ray end otherwise.
  logic signed [IW-1:0] mx, my, ox, oy;
  logic signed [DW-1:0] dx, dy;
  logic signed [IW:0] sx, sy;
  logic signed [CW-1:0] cx_r, cy_r;
  logic hit_r, par_o_r;
  localparam logic signed [IW:0] HI = (IW+1)'((64'sd1 <<< (CW-1)) - 1);
  localparam logic signed [IW:0] LO = -HI - 1;
  always_comb begin
    dx = DW'(x2_r[L-1]) - DW'(x1_r[L-1]);
    dy = DW'(y2_r[L-1]) - DW'(y1_r[L-1]);
    mx = $signed({1'b0, qq[TF]}) * dx;
    my = $signed({1'b0, qq[TF]}) * dy;
    ox = mx >>> TF;
    oy = my >>> TF;
    sx = (IW+1)'(x1_r[L-1]) + (IW+1)'(ox);
    sy = (IW+1)'(y1_r[L-1]) + (IW+1)'(oy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= ok_r[L-1];
      par_o_r <= par_r[L-1];
      if (ok_r[L-1]) begin
        cx_r <= (sx > HI) ? HI[CW-1:0] : (sx < LO) ? LO[CW-1:0] : sx[CW-1:0];
        cy_r <= (sy > HI) ? HI[CW-1:0] : (sy < LO) ? LO[CW-1:0] : sy[CW-1:0];
      end else begin
        cx_r <= x2_r[L-1];
        cy_r <= y2_r[L-1];
      end
    end
  end

  assign out_ch.valid = v_r[NS-1];
  assign out_ch.hit = hit_r;
  assign out_ch.parallel = par_o_r;
  assign out_ch.cross_x = cx_r;
  assign out_ch.cross_y = cy_r;
endmodule

FILE: src/sit_div_stage.sv
`timescale 1ns / 1ps
module sit_div_stage #(
  parameter int W = 35
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] r_in,
  input  logic [W-1:0] d_in,
  input  logic [16:0]  q_in,
  output logic [W-1:0] r_out,
  output logic [W-1:0] d_out,
  output logic [16:0]  q_out
);
  logic [W:0] sh;
  logic       ge;
  assign sh = {r_in, 1'b0};
  assign ge = sh >= {1'b0, d_in};
  always_ff @(posedge clk) begin
    if (en) begin
      r_out <= ge ? W'(sh - {1'b0, d_in}) : sh[W-1:0];
      d_out <= d_in;
      q_out <= {q_in[15:0], ge};
    end
  end
endmodule

FILE: tb/sv/segment_intersection_checker.sv
`timescale 1ns / 1ps
module segment_intersection_checker #(
  parameter int CW = sit_pkg::COORD_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  sit_in_if.sink in_mon,
  sit_out_if.sink out_mon,
  output int fail_count,
  output int pending
);
  typedef struct packed {
    logic hit;
    logic parallel;
    logic signed [CW-1:0] cross_x;
    logic signed [CW-1:0] cross_y;
  } crossing_t;

  crossing_t crossing_q[$];

  function automatic logic signed [CW-1:0] lerp_point(
      input logic signed [CW-1:0] s, input logic signed [CW-1:0] e, input longint q);
    longint prod;
    longint off;
    longint v;
    longint hi_lim;
    prod = q * (longint'(e) - longint'(s));
    off = prod >>> sit_pkg::T_FRAC;
    v = longint'(s) + off;
    hi_lim = (longint'(1) <<< (CW - 1)) - 1;
    if (v > hi_lim) v = hi_lim;
    if (v < -hi_lim - 1) v = -hi_lim - 1;
    return v[CW-1:0];
  endfunction

  function automatic crossing_t predict_crossing(
      input logic signed [CW-1:0] x1, input logic signed [CW-1:0] y1,
      input logic signed [CW-1:0] x2, input logic signed [CW-1:0] y2,
      input logic signed [CW-1:0] x3, input logic signed [CW-1:0] y3,
      input logic signed [CW-1:0] x4, input logic signed [CW-1:0] y4,
      input logic present);
    crossing_t r;
    logic signed [127:0] den;
    logic signed [127:0] tn;
    logic signed [127:0] un;
    logic signed [127:0] rem;
    longint q;
    r.hit = 1'b0;
    r.cross_x = x2;
    r.cross_y = y2;
    den = 128'(longint'(x1) - x2) * 128'(longint'(y3) - y4)
        - 128'(longint'(y1) - y2) * 128'(longint'(x3) - x4);
    tn = 128'(longint'(x1) - x3) * 128'(longint'(y3) - y4)
       - 128'(longint'(y1) - y3) * 128'(longint'(x3) - x4);
    un = 128'(longint'(y1) - y2) * 128'(longint'(x1) - x3)
       - 128'(longint'(x1) - x2) * 128'(longint'(y1) - y3);
    r.parallel = (den == 0);
    if (den != 0) begin
      if (den < 0) begin
        den = -den;
        tn = -tn;
        un = -un;
      end
      if (tn >= 0 && tn <= den && un >= 0 && un <= den && present) begin
        r.hit = 1'b1;
        if (tn == den) begin
          q = longint'(1) <<< sit_pkg::T_FRAC;
        end else begin
          q = 0;
          rem = tn;
          for (int i = 0; i < sit_pkg::T_FRAC; i++) begin
            rem = rem <<< 1;
            q = q <<< 1;
            if (rem >= den) begin
              rem = rem - den;
              q = q | 1;
            end
          end
        end
        r.cross_x = lerp_point(x1, x2, q);
        r.cross_y = lerp_point(y1, y2, q);
      end
    end
    return r;
  endfunction

  assign pending = crossing_q.size();

  always @(posedge clk) begin
    crossing_t got;
    crossing_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        crossing_q.push_back(predict_crossing(in_mon.ray_start_x, in_mon.ray_start_y,
            in_mon.ray_end_x, in_mon.ray_end_y, in_mon.wall_start_x, in_mon.wall_start_y,
            in_mon.wall_end_x, in_mon.wall_end_y, in_mon.wall_present));
      end
      if (out_mon.valid && out_mon.ready) begin
        got.hit = out_mon.hit;
        got.parallel = out_mon.parallel;
        got.cross_x = out_mon.cross_x;
        got.cross_y = out_mon.cross_y;
        if (crossing_q.size() == 0) begin
          $error("unexpected result item");
          fail_count <= fail_count + 1;
        end else begin
          want = crossing_q.pop_front();
          if (got !== want) begin
            if (got.hit !== want.hit)
              $error("hit: expected %0d, got %0d", want.hit, got.hit);
            if (got.parallel !== want.parallel)
              $error("parallel: expected %0d, got %0d", want.parallel, got.parallel);
            if (got.cross_x !== want.cross_x)
              $error("cross_x: expected %0d, got %0d", want.cross_x, got.cross_x);
            if (got.cross_y !== want.cross_y)
              $error("cross_y: expected %0d, got %0d", want.cross_y, got.cross_y);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: tb/sv/segment_intersection_test_tb.sv
`timescale 1ns / 1ps
module segment_intersection_test_tb;
  localparam int CW = sit_pkg::COORD_BITS_DEF;
  localparam int RANDOM_ITEMS = 1800;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int fail_count;
  int pending;
  int gap_left = 0;
  int burst_left = 0;
  int stall_mode = 0;
  logic [15:0] coords [8];
  logic present_bit;

  sit_in_if #(.CW(CW)) in_ch (.clk(clk));
  sit_out_if #(.CW(CW)) out_ch (.clk(clk));

  segment_intersection_test u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  segment_intersection_checker #(.CW(CW)) u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.ray_start_x = '0;
    in_ch.ray_start_y = '0;
    in_ch.ray_end_x = '0;
    in_ch.ray_end_y = '0;
    in_ch.wall_start_x = '0;
    in_ch.wall_start_y = '0;
    in_ch.wall_end_x = '0;
    in_ch.wall_end_y = '0;
    in_ch.wall_present = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_mode == 0) out_ch.ready <= 1'b1;
    else if (stall_mode == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= ($urandom_range(0, 2) == 0);
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
  end

  task automatic send_item(input logic [15:0] c [8], input logic p);
    while (gap_left > 0) begin
      @(posedge clk);
      gap_left--;
    end
    in_ch.valid <= 1'b1;
    in_ch.ray_start_x <= c[0];
    in_ch.ray_start_y <= c[1];
    in_ch.ray_end_x <= c[2];
    in_ch.ray_end_y <= c[3];
    in_ch.wall_start_x <= c[4];
    in_ch.wall_start_y <= c[5];
    in_ch.wall_end_x <= c[6];
    in_ch.wall_end_y <= c[7];
    in_ch.wall_present <= p;
    do @(posedge clk); while (!in_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_left > 0) in_ch.valid <= 1'b0;
    end
  endtask

  task automatic send_points(input int a, input int b, input int c, input int d,
                             input int e, input int f, input int g, input int h,
                             input logic p);
    logic [15:0] v [8];
    v[0] = 16'(a); v[1] = 16'(b); v[2] = 16'(c); v[3] = 16'(d);
    v[4] = 16'(e); v[5] = 16'(f); v[6] = 16'(g); v[7] = 16'(h);
    send_item(v, p);
  endtask

  function automatic logic [15:0] rand_coord(input int span);
    if (span == 0) return 16'($urandom());
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  initial begin
    int span;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_points(0, 0, 160, 160, 0, 160, 160, 0, 1'b1);
    send_points(0, 0, 160, 160, 0, 160, 160, 0, 1'b0);
    send_points(0, 0, 160, 0, 0, 16, 160, 16, 1'b1);
    send_points(0, 0, 160, 0, 32, 0, 96, 0, 1'b1);
    send_points(0, 0, 0, 0, 0, 16, 16, 0, 1'b1);
    send_points(0, 0, 160, 0, 0, 0, 0, 160, 1'b1);
    send_points(0, 0, 160, 0, 160, -80, 160, 80, 1'b1);
    send_points(0, 0, 160, 0, 80, 0, 80, 160, 1'b1);
    send_points(0, 0, 160, 0, 80, 1, 80, 160, 1'b1);
    send_points(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 1'b1);
    send_points(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767, 1'b1);
    send_points(-32768, 0, 32767, 0, 0, -32768, 0, 32767, 1'b1);
    send_points(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767, 1'b1);
    send_points(0, 0, 3, 7, 3, 0, 0, 7, 1'b1);
    send_points(-5, 3, 7, -9, -6, -6, 11, 4, 1'b1);
    send_points(-1, -1, -1, -1, -1, -1, -1, -1, 1'b1);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        if (gap_left == 0) in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      case ($urandom_range(0, 3))
        0: span = 0;
        1: span = 64;
        2: span = 4000;
        default: span = 20000;
      endcase
      for (int k = 0; k < 8; k++) coords[k] = rand_coord(span);
      if ($urandom_range(0, 2) == 0) begin
        coords[2] = 16'(-int'($signed(coords[0])) + ($urandom_range(0, 1) ? 1 : 0));
        coords[3] = 16'(-int'($signed(coords[1])));
        coords[4] = 16'(-int'($signed(coords[1])));
        coords[5] = coords[0];
        coords[6] = coords[1];
        coords[7] = 16'(-int'($signed(coords[0])));
      end
      if ($urandom_range(0, 9) == 0) begin
        coords[6] = coords[4] + (coords[2] - coords[0]);
        coords[7] = coords[5] + (coords[3] - coords[1]);
      end
      present_bit = ($urandom_range(0, 7) != 0);
      send_item(coords, present_bit);
    end
    if (gap_left == 0) in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
